// File: src/shs_pkg.sv
// ----------------------------------------------------------------------------
// shs_pkg
// shared types, constants and round functions of the sha-256 stream hasher
// ----------------------------------------------------------------------------
package shs_pkg;

  localparam int unsigned BlockBits = 512;
  localparam int unsigned WordBits  = 32;
  localparam int unsigned LenBits   = 64;
  localparam int unsigned MsgBits   = 61;

  localparam logic [5:0] LEN_FILL   = 6'd56;
  localparam logic [5:0] LAST_FILL  = 6'd63;
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [2:0] LAST_IDX   = 3'd7;
  localparam logic [7:0] PAD_BYTE   = 8'h80;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // source of the byte shifted into the block buffer
  typedef enum logic [1:0] {
    BYTE_DATA,
    BYTE_PAD,
    BYTE_ZERO
  } byte_sel_t;

  // commands from controller to datapath
  typedef struct packed {
    logic       shift_byte;
    byte_sel_t  byte_sel;
    logic       count_byte;
    logic       shift_len;
    logic       load_work;
    logic       round_en;
    logic [5:0] rnd;
    logic       update;
    logic       restart;
    logic [2:0] idx;
  } shs_cmd_t;

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

// File: src/shs_ctrl.sv
// ----------------------------------------------------------------------------
// shs_ctrl
// sequencer: byte intake, padding, round counting and digest output
// ----------------------------------------------------------------------------
module shs_ctrl
  import shs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  logic     op,
  output logic     out_valid,
  input  logic     out_stall,
  output shs_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_ROUND,
    S_UPDATE,
    S_EMIT
  } state_t;

  state_t     state;
  logic [5:0] fill;
  logic [5:0] rnd;
  logic [2:0] idx;
  logic       padding;
  logic       fin;

  logic in_acc;
  logic out_acc;

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_EMIT);
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;

  always_comb begin
    cmd            = '0;
    cmd.byte_sel   = BYTE_DATA;
    cmd.rnd        = rnd;
    cmd.idx        = idx;
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          cmd.shift_byte = 1'b1;
          cmd.byte_sel   = op ? BYTE_PAD : BYTE_DATA;
          cmd.count_byte = !op;
          cmd.load_work  = (fill == LAST_FILL);
        end
      end
      S_PAD: begin
        if (fill == LEN_FILL) begin
          cmd.shift_len = 1'b1;
          cmd.load_work = 1'b1;
        end else begin
          cmd.shift_byte = 1'b1;
          cmd.byte_sel   = BYTE_ZERO;
          cmd.load_work  = (fill == LAST_FILL);
        end
      end
      S_ROUND:  cmd.round_en = 1'b1;
      S_UPDATE: cmd.update   = 1'b1;
      S_EMIT:   cmd.restart  = out_acc && (idx == LAST_IDX);
      default:  cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      fill    <= '0;
      rnd     <= '0;
      idx     <= '0;
      padding <= 1'b0;
      fin     <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            fill    <= fill + 6'd1;
            padding <= op;
            rnd     <= '0;
            if (fill == LAST_FILL) begin
              state <= S_ROUND;
            end else if (op) begin
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          rnd <= '0;
          if (fill == LEN_FILL) begin
            fill  <= '0;
            fin   <= 1'b1;
            state <= S_ROUND;
          end else begin
            fill <= fill + 6'd1;
            if (fill == LAST_FILL) begin
              state <= S_ROUND;
            end
          end
        end
        S_ROUND: begin
          rnd <= rnd + 6'd1;
          if (rnd == LAST_ROUND) begin
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          idx <= '0;
          priority if (fin) begin
            state <= S_EMIT;
          end else if (padding) begin
            state <= S_PAD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (out_acc) begin
            idx <= idx + 3'd1;
            if (idx == LAST_IDX) begin
              fin     <= 1'b0;
              padding <= 1'b0;
              state   <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a block is only compressed once the buffer has wrapped back to empty
  a_fill_empty_in_rounds: assert property (@(posedge clk) disable iff (rst)
    state == S_ROUND |-> fill == 6'd0)
    else $error("compression started with a partly filled buffer");

  a_round_starts_at_zero: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND && $past(state) != S_ROUND) |-> rnd == 6'd0)
    else $error("round counter not cleared at block start");

  a_emit_starts_at_zero: assert property (@(posedge clk) disable iff (rst)
    $rose(state == S_EMIT) |-> (idx == 3'd0 && fin))
    else $error("digest output entered out of order");

  a_emit_only_after_update: assert property (@(posedge clk) disable iff (rst)
    $rose(state == S_EMIT) |-> $past(state) == S_UPDATE)
    else $error("digest shown before final hash update");

endmodule

// File: src/shs_datapath.sv
// ----------------------------------------------------------------------------
// shs_datapath
// block buffer and message schedule window, round logic, hash state
// ----------------------------------------------------------------------------
module shs_datapath
  import shs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  shs_cmd_t    cmd,
  input  logic [7:0]  data_byte,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  logic [BlockBits-1:0] blk;
  logic [MsgBits-1:0]   msg_bytes;
  logic [31:0]          hash [8];
  logic [31:0]          wk   [8];

  logic [7:0]  byte_in;
  logic [31:0] w_cur;
  logic [31:0] w_new;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [LenBits-1:0] bit_len;

  assign bit_len = {msg_bytes, 3'b000};

  always_comb begin
    unique case (cmd.byte_sel)
      BYTE_DATA: byte_in = data_byte;
      BYTE_PAD:  byte_in = PAD_BYTE;
      BYTE_ZERO: byte_in = 8'h00;
      default:   byte_in = 8'h00;
    endcase
  end

  // window word j sits j words below the top end, word 0 is the current round's word
  assign w_cur = blk[511:480];
  assign w_new = blk[511:480] + small_sigma0(blk[479:448]) + blk[223:192]
               + small_sigma1(blk[63:32]);

  assign t1 = wk[7] + big_sigma1(wk[4]) + ((wk[4] & wk[5]) ^ (~wk[4] & wk[6]))
            + ROUND_K[cmd.rnd] + w_cur;
  assign t2 = big_sigma0(wk[0]) + ((wk[0] & wk[1]) ^ (wk[0] & wk[2]) ^ (wk[1] & wk[2]));

  always_ff @(posedge clk) begin
    if (cmd.shift_byte) begin
      blk <= {blk[BlockBits-9:0], byte_in};
    end else if (cmd.shift_len) begin
      blk <= {blk[BlockBits-LenBits-1:0], bit_len};
    end else if (cmd.round_en) begin
      blk <= {blk[BlockBits-WordBits-1:0], w_new};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_work) begin
      for (int i = 0; i < 8; i++) begin
        wk[i] <= hash[i];
      end
    end else if (cmd.round_en) begin
      wk[0] <= t1 + t2;
      wk[1] <= wk[0];
      wk[2] <= wk[1];
      wk[3] <= wk[2];
      wk[4] <= wk[3] + t1;
      wk[5] <= wk[4];
      wk[6] <= wk[5];
      wk[7] <= wk[6];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      msg_bytes <= '0;
      for (int i = 0; i < 8; i++) begin
        hash[i] <= H_INIT[i];
      end
    end else begin
      if (cmd.count_byte) begin
        msg_bytes <= msg_bytes + {{(MsgBits-1){1'b0}}, 1'b1};
      end
      if (cmd.update) begin
        for (int i = 0; i < 8; i++) begin
          hash[i] <= hash[i] + wk[i];
        end
      end
    end
  end

  assign digest_word = hash[cmd.idx];
  assign word_index  = cmd.idx;
  assign last_word   = (cmd.idx == LAST_IDX);

endmodule

// File: src/sha256_stream_hasher_core.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher_core
// sha-256 over a byte stream, eight digest words per finished message
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_stall with op and data_byte. op 0 absorbs
//   one message byte, op 1 finishes the message. an item is taken when
//   in_valid is high and in_stall is low.
//   output channel: out_valid / out_stall with digest_word, word_index and
//   last_word. a finish gives eight items, word 0 (most significant) first,
//   last_word set on word 7.
// sequence
//   absorb items are taken back to back while idle; the 64th byte of a
//   block starts the 64 rounds plus the hash update, with in_stall high.
//   a finish pads one zero byte a cycle up to byte 56, then shifts in
//   the length and compresses the block; when the pad byte falls past
//   byte 55 the block is first zero-filled to its end and compressed.
//   the first digest word shows in the cycle after the last hash update.
// stall and reset
//   in_stall is high whenever the block is not idle; digest words hold
//   while out_stall is high, no new item is taken until word 7 has left.
//   rst (synchronous, active high) loads the initial hash value and clears
//   the length and fill counters; the block buffer needs no reset.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_core
  import shs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op,
  input  logic [7:0]  data_byte,
  // digest items
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  // command bundle from the sequencer to the datapath
  shs_cmd_t cmd;

  // sequencer: fill count, padding steps, round count, output index
  shs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // datapath: block buffer doubling as schedule window, round unit, hash
  shs_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .data_byte   (data_byte),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word)
  );

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the sha-256 stream hasher: a short table of
// directed items, some checked against known digests, then random messages
// of random and block-edge lengths, each digest word compared with a
// bit-level sha-256 model kept inside the bench
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // item operations
  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  localparam int          IDLE_PCT     = 14;
  localparam int          RANDOM_ITEMS = 140;
  localparam int          DRAIN_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int          NUM_ROWS     = 18;
  localparam logic [7:0]  PAD_MARK     = 8'h80;
  localparam int          LEN_SLOT     = 56;

  // well-known digests, used where the answer is plain
  localparam logic [255:0] DIGEST_EMPTY =
    256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855;
  localparam logic [255:0] DIGEST_ABC =
    256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad;

  localparam logic [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // one row of the directed table
  typedef struct packed {
    logic         cmd;
    logic [7:0]   val;
    logic         known_ok;
    logic [255:0] known;
  } stim_row_t;

  // one digest word as it should leave the block
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_item_t;

  // directed items: empty message right after reset and twice in a row,
  // "abc", empty again after a real message, byte extremes, one-byte
  // messages
  localparam stim_row_t DIRECTED [NUM_ROWS] = '{
    '{OP_FINISH, 8'h00, 1'b1, DIGEST_EMPTY},
    '{OP_FINISH, 8'hff, 1'b1, DIGEST_EMPTY},
    '{OP_ABSORB, 8'h61, 1'b0, 256'h0},
    '{OP_ABSORB, 8'h62, 1'b0, 256'h0},
    '{OP_ABSORB, 8'h63, 1'b0, 256'h0},
    '{OP_FINISH, 8'h00, 1'b1, DIGEST_ABC},
    '{OP_FINISH, 8'h00, 1'b1, DIGEST_EMPTY},
    '{OP_ABSORB, 8'h00, 1'b0, 256'h0},
    '{OP_ABSORB, 8'hff, 1'b0, 256'h0},
    '{OP_ABSORB, 8'h80, 1'b0, 256'h0},
    '{OP_ABSORB, 8'h7f, 1'b0, 256'h0},
    '{OP_ABSORB, 8'h55, 1'b0, 256'h0},
    '{OP_ABSORB, 8'haa, 1'b0, 256'h0},
    '{OP_FINISH, 8'h5a, 1'b0, 256'h0},
    '{OP_ABSORB, 8'hff, 1'b0, 256'h0},
    '{OP_FINISH, 8'h00, 1'b0, 256'h0},
    '{OP_ABSORB, 8'h00, 1'b0, 256'h0},
    '{OP_FINISH, 8'hff, 1'b0, 256'h0}
  };

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        op;
  logic [7:0]  data_byte;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  // when set, neither side idles
  logic quiet;

  int unsigned mismatch_count;
  int unsigned cycle_count;

  // digest words still owed by the block, oldest first
  digest_item_t pending_words [$];

  // bench copy of the hasher state
  logic [31:0] hash_st [8];
  logic [7:0]  blk [64];
  logic [5:0]  fill;
  logic [60:0] msg_len;

  sha256_stream_hasher_core dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .data_byte   (data_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word)
  );

  // 12 ns clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  task automatic note_mismatch(input string what);
    mismatch_count++;
    $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  function automatic logic [31:0] ror32(input logic [31:0] v, input int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  // ---------------------------------------------------------------------
  // sha-256 model
  // ---------------------------------------------------------------------
  task automatic sha_restart();
    int i;
    for (i = 0; i < 8; i++) hash_st[i] = SHA_IV[i];
    fill    = '0;
    msg_len = '0;
  endtask

  // one 64-round compression of blk into hash_st
  task automatic sha_compress();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h;
    logic [31:0] s0, s1, t1, t2;
    int i;
    for (i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (i = 16; i < 64; i++) begin
      s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    a = hash_st[0]; b = hash_st[1]; c = hash_st[2]; d = hash_st[3];
    e = hash_st[4]; f = hash_st[5]; g = hash_st[6]; h = hash_st[7];
    for (i = 0; i < 64; i++) begin
      t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) +
           ((e & f) ^ (~e & g)) + SHA_K[i] + w[i];
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) +
           ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    hash_st[0] += a; hash_st[1] += b; hash_st[2] += c; hash_st[3] += d;
    hash_st[4] += e; hash_st[5] += f; hash_st[6] += g; hash_st[7] += h;
  endtask

  task automatic sha_absorb(input logic [7:0] val);
    blk[fill] = val;
    msg_len   = msg_len + 61'd1;  // wraps at 2^61 bytes
    fill      = fill + 6'd1;
    if (fill == 6'd0) sha_compress();
  endtask

  // pads, compresses and queues the eight digest words; a known digest,
  // where given, stands in for the computed one
  task automatic sha_finish(input logic use_known, input logic [255:0] known);
    logic [63:0]  bits;
    digest_item_t item;
    int pos;
    int i;
    bits     = {msg_len, 3'b000};
    blk[fill] = PAD_MARK;
    pos      = int'(fill) + 1;
    // pad byte past the length slot: spill into an extra block
    if (pos > LEN_SLOT) begin
      for (i = pos; i < 64; i++) blk[i] = 8'h00;
      sha_compress();
      pos = 0;
    end
    for (i = pos; i < LEN_SLOT; i++) blk[i] = 8'h00;
    for (i = 0; i < 8; i++) blk[63-i] = bits[8*i +: 8];
    sha_compress();
    for (i = 0; i < 8; i++) begin
      item.word = use_known ? known[255 - 32*i -: 32] : hash_st[i];
      item.idx  = 3'(i);
      item.last = (i == 7);
      pending_words.push_back(item);
    end
    sha_restart();
  endtask

  // ---------------------------------------------------------------------
  // sender: drives at the falling edge, sees acceptance at the rising edge
  // ---------------------------------------------------------------------
  task automatic send_item(input logic cmd, input logic [7:0] val,
                           input logic use_known, input logic [255:0] known);
    // random idle cycles before the item
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    op        <= cmd;
    data_byte <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // accepted at this edge: advance the model
    if (cmd == OP_FINISH) sha_finish(use_known, known);
    else sha_absorb(val);
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------
  // receiver: random stall at the falling edge
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // ---------------------------------------------------------------------
  // digest checker: each word taken is matched with the oldest one owed
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    digest_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        note_mismatch($sformatf("unexpected digest word %h index %0d",
                                digest_word, word_index));
      end else begin
        want = pending_words.pop_front();
        if (digest_word !== want.word)
          note_mismatch($sformatf("digest_word %h, want %h (index %0d)",
                                  digest_word, want.word, want.idx));
        if (word_index !== want.idx)
          note_mismatch($sformatf("word_index %0d, want %0d",
                                  word_index, want.idx));
        if (last_word !== want.last)
          note_mismatch($sformatf("last_word %b, want %b (index %0d)",
                                  last_word, want.last, want.idx));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL sha256_stream_hasher_core");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------
  initial begin
    int random_items;
    int msg_n;
    int msg_len_pick;
    int k;

    rst            = 1'b1;
    in_valid       = 1'b0;
    op             = OP_ABSORB;
    data_byte      = 8'h00;
    out_stall      = 1'b0;
    quiet          = 1'b0;
    mismatch_count = 0;
    cycle_count    = 0;
    for (k = 0; k < 64; k++) blk[k] = 8'h00;
    sha_restart();

    // hold reset, then release it at a falling edge
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    for (k = 0; k < NUM_ROWS; k++)
      send_item(DIRECTED[k].cmd, DIRECTED[k].val, DIRECTED[k].known_ok,
                DIRECTED[k].known);

    // random messages; the early ones sit on the block edges:
    // pad byte at the last slot that still fits the length, pad byte just
    // past it (extra block), and a message of exactly one block
    random_items = 0;
    msg_n        = 0;
    while (random_items < RANDOM_ITEMS) begin
      // one long stretch with no idling on either side
      quiet <= (msg_n == 2 || msg_n == 3);
      // hold off until every owed digest word has come
      if (msg_n == 1) begin
        in_valid <= 1'b0;
        while (pending_words.size() != 0) @(negedge clk);
      end
      case (msg_n)
        1:       msg_len_pick = 55;
        2:       msg_len_pick = 56;
        4:       msg_len_pick = 64;
        default: begin
          if ($urandom_range(0, 99) < 15) msg_len_pick = $urandom_range(57, 63);
          else msg_len_pick = $urandom_range(0, 12);
        end
      endcase
      for (k = 0; k < msg_len_pick; k++) begin
        send_item(OP_ABSORB, 8'($urandom_range(0, 255)), 1'b0, 256'h0);
        random_items++;
      end
      // data byte on a finish is don't-care, so make it random too
      send_item(OP_FINISH, 8'($urandom_range(0, 255)), 1'b0, 256'h0);
      random_items++;
      msg_n++;
    end
    in_valid <= 1'b0;
    quiet    <= 1'b0;

    // wait for the last digest, then let the block settle
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_words.size() != 0)
      note_mismatch($sformatf("%0d digest words never came", pending_words.size()));

    if (mismatch_count == 0) begin
      $display("PASS sha256_stream_hasher_core");
    end else begin
      $display("FAIL sha256_stream_hasher_core");
    end
    $finish;
  end

endmodule
